// ----- rtl/hsv2rgb_pkg.sv -----
// ----------------------------------------------------------------------------
// HSV to RGB package
// Constants, reciprocal multipliers and item types shared by the converter.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  // Input limits and the rounding offsets used when rescaling to 0..255.
  localparam logic [8:0] HUE_MAX  = 9'd360;
  localparam logic [8:0] HUE_HALF = 9'd180;
  localparam logic [6:0] PCT_MAX  = 7'd100;
  localparam logic [6:0] PCT_HALF = 7'd50;

  localparam logic [7:0] FULL_SCALE   = 8'd255;
  localparam logic [7:0] SECTOR_STEPS = 8'd43;
  localparam logic [7:0] REM_SCALE    = 8'd6;

  // Division by a constant is a multiply by a rounded-up reciprocal and a shift.
  // Each pair is exact over the full range of its numerator.
  localparam logic [17:0] HUE_RECIP    = 18'd186414;
  localparam int          HUE_SHIFT    = 26;
  localparam logic [15:0] PCT_RECIP    = 16'd41944;
  localparam int          PCT_SHIFT    = 22;
  localparam logic [7:0]  SECTOR_RECIP = 8'd191;
  localparam int          SECTOR_SHIFT = 13;

  // Hue sectors of the color wheel, in order of increasing hue.
  typedef enum logic [2:0] {
    SEC_RED_YELLOW   = 3'd0,
    SEC_YELLOW_GREEN = 3'd1,
    SEC_GREEN_CYAN   = 3'd2,
    SEC_CYAN_BLUE    = 3'd3,
    SEC_BLUE_MAGENTA = 3'd4,
    SEC_MAGENTA_RED  = 3'd5
  } sector_t;

  // Hue, saturation and value rescaled to 0..255.
  typedef struct packed {
    logic [7:0] h;
    logic [7:0] s;
    logic [7:0] v;
  } hsv_byte_t;

  // Operands handed from the sector split to the shading stages.
  typedef struct packed {
    sector_t    sector;
    logic       grey;
    logic [7:0] s;
    logic [7:0] v;
    logic [7:0] p;
    logic [7:0] rem;
  } shade_op_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

endpackage

// ----- rtl/hsv2rgb_if.sv -----
// ----------------------------------------------------------------------------
// HSV to RGB channel interfaces
// Valid/ready channels for the color request and the RGB result.
// ----------------------------------------------------------------------------
interface hsv2rgb_in_if;
  logic       valid;
  logic       ready;
  logic [8:0] hue;
  logic [6:0] saturation;
  logic [6:0] brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface

interface hsv2rgb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// ----- rtl/hsv2rgb_scale.sv -----
// ----------------------------------------------------------------------------
// HSV to RGB input scaling stage
// Clamps hue, saturation and value and rescales each to 0..255 with rounding.
// ----------------------------------------------------------------------------
module hsv2rgb_scale
  import hsv2rgb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [8:0] in_hue,
  input  logic [6:0] in_saturation,
  input  logic [6:0] in_brightness,
  output logic       out_valid,
  input  logic       out_ready,
  output hsv_byte_t  out_data
);

  logic [8:0]  hue_clamp;
  logic [16:0] hue_num;
  logic [34:0] hue_prod;
  logic [6:0]  sat_clamp;
  logic [6:0]  bri_clamp;
  logic [14:0] sat_num;
  logic [14:0] bri_num;
  logic [30:0] sat_prod;
  logic [30:0] bri_prod;
  logic        valid_r;
  hsv_byte_t   data_r;
  hsv_byte_t   data_nxt;

  // x*255 is formed as x*256 - x, then the rounding offset is added.
  always_comb begin
    hue_clamp = (in_hue > HUE_MAX) ? HUE_MAX : in_hue;
    sat_clamp = (in_saturation > PCT_MAX) ? PCT_MAX : in_saturation;
    bri_clamp = (in_brightness > PCT_MAX) ? PCT_MAX : in_brightness;

    hue_num = ({hue_clamp, 8'd0} - {8'd0, hue_clamp}) + {8'd0, HUE_HALF};
    sat_num = ({sat_clamp, 8'd0} - {8'd0, sat_clamp}) + {8'd0, PCT_HALF};
    bri_num = ({bri_clamp, 8'd0} - {8'd0, bri_clamp}) + {8'd0, PCT_HALF};

    hue_prod = 35'(hue_num) * 35'(HUE_RECIP);
    sat_prod = 31'(sat_num) * 31'(PCT_RECIP);
    bri_prod = 31'(bri_num) * 31'(PCT_RECIP);

    data_nxt.h = hue_prod[HUE_SHIFT +: 8];
    data_nxt.s = sat_prod[PCT_SHIFT +: 8];
    data_nxt.v = bri_prod[PCT_SHIFT +: 8];
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ----- rtl/hsv2rgb_sector.sv -----
// ----------------------------------------------------------------------------
// HSV to RGB sector split
// Two stages: sector number and the p term, then the scaled sector remainder.
// ----------------------------------------------------------------------------
module hsv2rgb_sector
  import hsv2rgb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  hsv_byte_t in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output shade_op_t out_data
);

  logic [15:0] sec_prod;
  logic [15:0] pv_prod;
  logic        a_valid_r;
  logic        a_ready;
  sector_t     a_sector_r;
  logic [7:0]  a_h_r;
  logic [7:0]  a_s_r;
  logic [7:0]  a_v_r;
  logic [15:0] a_pv_r;

  logic [7:0]  base;
  logic [7:0]  offset;
  logic        b_valid_r;
  logic        b_ready;
  shade_op_t   b_data_r;
  shade_op_t   b_data_nxt;

  // First stage: h / 43 by reciprocal, and v * (255 - s).
  assign sec_prod = 16'(in_data.h) * 16'(SECTOR_RECIP);
  assign pv_prod  = 16'(in_data.v) * 16'(FULL_SCALE - in_data.s);

  assign b_ready  = !b_valid_r || out_ready;
  assign a_ready  = !a_valid_r || b_ready;
  assign in_ready = a_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (a_ready) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_valid) begin
      a_sector_r <= sector_t'(sec_prod[SECTOR_SHIFT +: 3]);
      a_h_r      <= in_data.h;
      a_s_r      <= in_data.s;
      a_v_r      <= in_data.v;
      a_pv_r     <= pv_prod;
    end
  end

  // Second stage: remainder within the sector, scaled by 6 (stays below 256).
  always_comb begin
    base   = 8'({5'd0, a_sector_r} * SECTOR_STEPS);
    offset = a_h_r - base;
    b_data_nxt.sector = a_sector_r;
    b_data_nxt.grey   = (a_s_r == 8'd0);
    b_data_nxt.s      = a_s_r;
    b_data_nxt.v      = a_v_r;
    b_data_nxt.p      = a_pv_r[15:8];
    b_data_nxt.rem    = 8'(offset * REM_SCALE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (b_ready) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_valid_r) begin
      b_data_r <= b_data_nxt;
    end
  end

  assign out_valid = b_valid_r;
  assign out_data  = b_data_r;

endmodule

// ----- rtl/hsv2rgb_shade.sv -----
// ----------------------------------------------------------------------------
// HSV to RGB shading stages
// Forms the q and t terms and orders the channels by sector.
// ----------------------------------------------------------------------------
module hsv2rgb_shade
  import hsv2rgb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  shade_op_t in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output rgb_t      out_data
);

  logic [15:0] sq_prod;
  logic [15:0] st_prod;
  logic        c_valid_r;
  logic        c_ready;
  sector_t     c_sector_r;
  logic        c_grey_r;
  logic [7:0]  c_v_r;
  logic [7:0]  c_p_r;
  logic [7:0]  c_sq_r;
  logic [7:0]  c_st_r;

  logic [15:0] q_prod;
  logic [15:0] t_prod;
  logic [7:0]  q;
  logic [7:0]  t;
  logic        d_valid_r;
  logic        d_ready;
  rgb_t        d_data_r;
  rgb_t        d_data_nxt;

  // First stage: saturation weighted by the remainder and by its complement.
  assign sq_prod = 16'(in_data.s) * 16'(in_data.rem);
  assign st_prod = 16'(in_data.s) * 16'(FULL_SCALE - in_data.rem);

  assign d_ready  = !d_valid_r || out_ready;
  assign c_ready  = !c_valid_r || d_ready;
  assign in_ready = c_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else if (c_ready) begin
      c_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (c_ready && in_valid) begin
      c_sector_r <= in_data.sector;
      c_grey_r   <= in_data.grey;
      c_v_r      <= in_data.v;
      c_p_r      <= in_data.p;
      c_sq_r     <= sq_prod[15:8];
      c_st_r     <= st_prod[15:8];
    end
  end

  // Second stage: q and t, then the sector multiplexer.
  assign q_prod = 16'(c_v_r) * 16'(FULL_SCALE - c_sq_r);
  assign t_prod = 16'(c_v_r) * 16'(FULL_SCALE - c_st_r);
  assign q      = q_prod[15:8];
  assign t      = t_prod[15:8];

  always_comb begin
    if (c_grey_r) begin
      d_data_nxt = '{red: c_v_r, green: c_v_r, blue: c_v_r};
    end else begin
      unique case (c_sector_r)
        SEC_RED_YELLOW:   d_data_nxt = '{red: c_v_r, green: t,     blue: c_p_r};
        SEC_YELLOW_GREEN: d_data_nxt = '{red: q,     green: c_v_r, blue: c_p_r};
        SEC_GREEN_CYAN:   d_data_nxt = '{red: c_p_r, green: c_v_r, blue: t};
        SEC_CYAN_BLUE:    d_data_nxt = '{red: c_p_r, green: q,     blue: c_v_r};
        SEC_BLUE_MAGENTA: d_data_nxt = '{red: t,     green: c_p_r, blue: c_v_r};
        default:          d_data_nxt = '{red: c_v_r, green: c_p_r, blue: q};
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r <= 1'b0;
    end else if (d_ready) begin
      d_valid_r <= c_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (d_ready && c_valid_r) begin
      d_data_r <= d_data_nxt;
    end
  end

  assign out_valid = d_valid_r;
  assign out_data  = d_data_r;

endmodule

// ----- rtl/hsv_to_rgb_converter_core.sv -----
// ----------------------------------------------------------------------------
// HSV to RGB converter core
// Converts one HSV request into 8-bit red, green, blue per cycle unless stalled.
// ----------------------------------------------------------------------------
//
//   Channel | Dir | Handshake     | Payload
//   --------+-----+---------------+------------------------------------------
//   in_chan | in  | valid / ready | hue[8:0], saturation[6:0], brightness[6:0]
//   out_chan| out | valid / ready | red[7:0], green[7:0], blue[7:0]
//
// One request is accepted every cycle while out_chan does not stall. Each result
// passes through the five register stages of the pipeline before it is offered
// on out_chan.
// Reset (rst_n low, synchronous) empties every stage; payload is not cleared.
// Each stage holds its own valid bit and loads whenever it is empty or the
// stage after it moves, so bubbles close up and a stall at the output backs up
// one stage at a time without dropping or repeating a request.
//
// Stage plan:
//   1. Clamp and rescale hue, saturation and value to 0..255. The divisions
//      by 360 and 100 are multiplies by rounded-up reciprocals.
//   2. Sector number (hue / 43 by reciprocal) and v * (255 - s).
//   3. Remainder inside the sector times 6, p term, grey flag.
//   4. Saturation weighted by the remainder and by its complement.
//   5. q and t terms, sector multiplexer, output register.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_core
  import hsv2rgb_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  hsv2rgb_in_if.sink   in_chan,
  hsv2rgb_out_if.source out_chan
);

  // Handshake between the pipeline sections.
  logic      scale_valid;
  logic      sector_ready;
  hsv_byte_t scale_data;
  logic      sec_valid;
  logic      shade_ready;
  shade_op_t sec_data;
  rgb_t      rgb_data;

  // Stage 1: clamp and rescale.
  hsv2rgb_scale u_scale (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_chan.valid),
    .in_ready      (in_chan.ready),
    .in_hue        (in_chan.hue),
    .in_saturation (in_chan.saturation),
    .in_brightness (in_chan.brightness),
    .out_valid     (scale_valid),
    .out_ready     (sector_ready),
    .out_data      (scale_data)
  );

  // Stages 2 and 3: sector split and the p term.
  hsv2rgb_sector u_sector (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (scale_valid),
    .in_ready  (sector_ready),
    .in_data   (scale_data),
    .out_valid (sec_valid),
    .out_ready (shade_ready),
    .out_data  (sec_data)
  );

  // Stages 4 and 5: q and t terms and the channel order. The last stage is
  // the output register, so the result holds steady while out_chan stalls.
  hsv2rgb_shade u_shade (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sec_valid),
    .in_ready  (shade_ready),
    .in_data   (sec_data),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_data  (rgb_data)
  );

  assign out_chan.red   = rgb_data.red;
  assign out_chan.green = rgb_data.green;
  assign out_chan.blue  = rgb_data.blue;

  // An empty first stage always takes a new request.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !scale_valid |-> in_chan.ready)
    else $error("input stalled while the first stage is empty");

  // A scaled item that cannot move on stays in the first stage.
  a_scale_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (scale_valid && !sector_ready) |=> scale_valid)
    else $error("scaled item lost during a stall");

  // The scaled remainder is a multiple of 6 no larger than 42 * 6.
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    sec_valid |-> (sec_data.rem[0] == 1'b0) && (sec_data.rem <= 8'd252))
    else $error("sector remainder out of range");

  // The p term never exceeds the value.
  a_p_below_v: assert property (@(posedge clk) disable iff (!rst_n)
    sec_valid |-> (sec_data.p <= sec_data.v))
    else $error("p term above value");

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// HSV to RGB converter core testbench
// Sends color requests through the valid/ready input channel and checks each
// RGB result against a cycle-free integer predictor of the conversion. Both
// channel ends idle at random, the output is held off for a long stretch, and
// the sender drains the pipeline in mid-run.
// ----------------------------------------------------------------------------

// Keeps the predicted colors in request order and checks results against them.
class color_scoreboard;
  hsv2rgb_pkg::rgb_t expected_q[$];
  int unsigned errors;
  int unsigned checked;

  // Clamps x to limit and rescales it to 0..255 with rounding.
  function logic [7:0] rescale(input logic [8:0] x, input logic [8:0] limit);
    logic [8:0]  clamped;
    logic [16:0] num;
    clamped = (x > limit) ? limit : x;
    num = 17'(clamped) * 17'd255 + 17'(limit >> 1);
    return 8'(num / 17'(limit));
  endfunction

  function hsv2rgb_pkg::rgb_t convert(input logic [8:0] hue, input logic [6:0] sat,
                                      input logic [6:0] bri);
    hsv2rgb_pkg::rgb_t rgb;
    logic [7:0] h, s, v, rem, p, q, t, s_rem, s_cmp;
    logic [7:0] sec;
    h = rescale(hue, 9'd360);
    s = rescale({2'b00, sat}, 9'd100);
    v = rescale({2'b00, bri}, 9'd100);
    if (s == 8'd0) begin
      rgb = '{red: v, green: v, blue: v};
    end else begin
      sec   = h / 8'd43;
      rem   = 8'((h - 8'(sec * 8'd43)) * 8'd6);
      p     = 8'((16'(v) * 16'(8'd255 - s)) >> 8);
      s_rem = 8'((16'(s) * 16'(rem)) >> 8);
      s_cmp = 8'((16'(s) * 16'(8'd255 - rem)) >> 8);
      q     = 8'((16'(v) * 16'(8'd255 - s_rem)) >> 8);
      t     = 8'((16'(v) * 16'(8'd255 - s_cmp)) >> 8);
      case (hsv2rgb_pkg::sector_t'(sec[2:0]))
        hsv2rgb_pkg::SEC_RED_YELLOW:   rgb = '{red: v, green: t, blue: p};
        hsv2rgb_pkg::SEC_YELLOW_GREEN: rgb = '{red: q, green: v, blue: p};
        hsv2rgb_pkg::SEC_GREEN_CYAN:   rgb = '{red: p, green: v, blue: t};
        hsv2rgb_pkg::SEC_CYAN_BLUE:    rgb = '{red: p, green: q, blue: v};
        hsv2rgb_pkg::SEC_BLUE_MAGENTA: rgb = '{red: t, green: p, blue: v};
        default:                       rgb = '{red: v, green: p, blue: q};
      endcase
    end
    return rgb;
  endfunction

  function void note_request(input logic [8:0] hue, input logic [6:0] sat,
                             input logic [6:0] bri);
    expected_q.push_back(convert(hue, sat, bri));
  endfunction

  function int unsigned pending();
    return expected_q.size();
  endfunction

  task report(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    errors++;
  endtask

  task check_result(input hsv2rgb_pkg::rgb_t got);
    hsv2rgb_pkg::rgb_t want;
    if (expected_q.size() == 0) begin
      report($sformatf("result %0d/%0d/%0d with no pending request",
                       got.red, got.green, got.blue));
    end else begin
      want = expected_q.pop_front();
      checked++;
      if (got.red !== want.red)
        report($sformatf("red got %0d expected %0d", got.red, want.red));
      if (got.green !== want.green)
        report($sformatf("green got %0d expected %0d", got.green, want.green));
      if (got.blue !== want.blue)
        report($sformatf("blue got %0d expected %0d", got.blue, want.blue));
    end
  endtask
endclass

module tb_top;
  import hsv2rgb_pkg::*;

  // The pipeline is five stages deep; a tail wait after the last result lets
  // a stray extra result be caught.
  localparam int unsigned PIPE_DEPTH   = 5;
  localparam int unsigned RANDOM_COUNT = 1550;
  localparam int unsigned HOLD_CYCLES  = 80;
  // The limit allows for both sides idling at their longest on every request,
  // plus the long hold.
  localparam int unsigned CYCLE_LIMIT  = 200000;

  logic clk;
  logic rst_n;

  hsv2rgb_in_if  in_if ();
  hsv2rgb_out_if out_if ();

  hsv_to_rgb_converter_core u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  color_scoreboard sb;

  // Stall shaping shared by the sender and the receiver. While no_idle is set
  // neither side inserts gaps; hold_request asks the receiver for one long
  // hold-off at its next result.
  bit          no_idle;
  bit          hold_request;
  int unsigned requests_sent;
  int unsigned directed_count;
  int unsigned grey_count;
  int unsigned clamp_count;
  int unsigned cycle_count;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Global watchdog; the run is expected to end long before this.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  // Everything is driven at the rising edge, so at the falling edge the
  // handshake signals are settled. A valid/ready pair seen high there is the
  // transfer that happens at the next rising edge.
  always @(negedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      sb.check_result('{red: out_if.red, green: out_if.green, blue: out_if.blue});
  end

  // Offers one color request after a random gap and holds it until the block
  // takes it. A zero gap keeps valid high across back-to-back requests.
  task send_color(input logic [8:0] hue, input logic [6:0] sat, input logic [6:0] bri);
    int unsigned gap;
    logic taken;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.hue        <= hue;
    in_if.saturation <= sat;
    in_if.brightness <= bri;
    do begin
      @(negedge clk);
      taken = in_if.ready;
      @(posedge clk);
    end while (!taken);
    sb.note_request(hue, sat, bri);
    requests_sent++;
    if (sat == 7'd0)
      grey_count++;
    if (hue > 9'd360 || sat > 7'd100 || bri > 7'd100)
      clamp_count++;
  endtask

  // Mostly in-range colors, a share of grey ones, and the rest anywhere in
  // the field widths so the clamping path sees plenty of traffic.
  task send_random_color();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70)
      send_color(9'($urandom_range(0, 360)), 7'($urandom_range(0, 100)),
                 7'($urandom_range(0, 100)));
    else if (pick < 80)
      send_color(9'($urandom_range(0, 511)), 7'd0, 7'($urandom_range(0, 127)));
    else
      send_color(9'($urandom_range(0, 511)), 7'($urandom_range(0, 127)),
                 7'($urandom_range(0, 127)));
  endtask

  // Stops offering requests until every predicted color has come back.
  task drain_pipeline();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Result side: a random hold-off before each result, with one long hold
  // when asked, so the pipeline fills and pushes back on the input.
  initial begin : receiver
    int unsigned gap;
    logic taken;
    out_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      gap = no_idle ? 0 : $urandom_range(0, 10);
      if (gap != 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do begin
        @(negedge clk);
        taken = out_if.valid;
        @(posedge clk);
      end while (!taken);
    end
  end

  initial begin : stimulus
    sb = new();
    in_if.valid      = 1'b0;
    in_if.hue        = '0;
    in_if.saturation = '0;
    in_if.brightness = '0;
    rst_n            = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed colors: field extremes, out-of-range values that clamp, every
    // hue sector with the boundary into the last sector, and grey colors.
    send_color(9'd0,   7'd0,   7'd0);
    send_color(9'd511, 7'd127, 7'd127);
    send_color(9'd360, 7'd100, 7'd100);
    send_color(9'd361, 7'd101, 7'd101);
    send_color(9'd0,   7'd100, 7'd100);
    send_color(9'd30,  7'd100, 7'd100);
    send_color(9'd61,  7'd100, 7'd40);
    send_color(9'd100, 7'd100, 7'd100);
    send_color(9'd150, 7'd75,  7'd100);
    send_color(9'd200, 7'd100, 7'd60);
    send_color(9'd240, 7'd100, 7'd100);
    send_color(9'd270, 7'd50,  7'd100);
    send_color(9'd302, 7'd100, 7'd100);
    send_color(9'd303, 7'd100, 7'd100);
    send_color(9'd330, 7'd100, 7'd100);
    send_color(9'd359, 7'd1,   7'd100);
    send_color(9'd400, 7'd127, 7'd80);
    send_color(9'd120, 7'd0,   7'd50);
    send_color(9'd200, 7'd0,   7'd127);
    send_color(9'd85,  7'd100, 7'd0);
    send_color(9'd255, 7'd64,  7'd64);
    directed_count = requests_sent;
    drain_pipeline();

    // Random colors in phases: plain random idling, a long output hold with
    // the sender running flat out, a mid-run drain, and a second gap-free run.
    for (int unsigned i = 0; i < RANDOM_COUNT; i++) begin
      if (i == 300) begin
        no_idle      = 1'b1;
        hold_request = 1'b1;
      end
      if (i == 500)
        no_idle = 1'b0;
      if (i == 800)
        drain_pipeline();
      if (i == 1100)
        no_idle = 1'b1;
      if (i == 1250)
        no_idle = 1'b0;
      send_random_color();
    end

    in_if.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (PIPE_DEPTH * 2) @(posedge clk);

    if (sb.pending() != 0)
      sb.report($sformatf("%0d expected colors never arrived", sb.pending()));

    $display("Converted %0d colors (%0d directed, %0d grey, %0d clamped), checked %0d results",
             requests_sent, directed_count, grey_count, clamp_count, sb.checked);
    $display("under random stalls on both sides, a long output hold and a mid-run drain.");
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
